### sv/mrr_pkg.sv
// Shared constants, types and ring geometry helper for the matrix ring rotator.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package mrr_pkg;

  localparam int unsigned MAX_N         = 32;
  localparam int unsigned ELEMENT_WIDTH = 64;

  // Matrix size register and its register-file decode.
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIZE = '0;
  localparam logic [CFG_W-1:0]     RESET_SIZE      = CFG_W'(4);

  // Row and column counters hold values up to MAX_N.
  localparam int unsigned SIZE_W    = $clog2(MAX_N + 1);
  // The window holds the last 2N elements.
  localparam int unsigned WIN_DEPTH = 2 * MAX_N;
  localparam int unsigned SLOT_W    = $clog2(WIN_DEPTH);

  // Where the element landing at an output position comes from.
  typedef enum logic [2:0] {
    SRC_CENTRE,
    SRC_TOP,
    SRC_RIGHT,
    SRC_BOTTOM,
    SRC_LEFT
  } src_dir_e;

  typedef struct packed {
    logic use_cur;
    logic run_last;
    logic frame_last;
  } job_t;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] element;
    logic                            run_last;
    logic                            frame_last;
  } out_item_t;

  // Classify an output position by the ring edge it sits on.
  function automatic src_dir_e src_dir(input logic [SIZE_W-1:0] r,
                                       input logic [SIZE_W-1:0] c,
                                       input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] nm1;
    logic [SIZE_W-1:0] rr;
    logic [SIZE_W-1:0] cc;
    logic [SIZE_W-1:0] d0;
    logic [SIZE_W-1:0] d1;
    logic [SIZE_W-1:0] d;
    logic [SIZE_W-1:0] far;
    src_dir_e          dir;
    nm1 = n - SIZE_W'(1);
    rr  = nm1 - r;
    cc  = nm1 - c;
    d0  = (r < c) ? r : c;
    d1  = (rr < cc) ? rr : cc;
    d   = (d0 < d1) ? d0 : d1;
    far = nm1 - d;
    if (r == d && c == d && far == d) begin
      dir = SRC_CENTRE;
    end else if (r == d && c > d) begin
      dir = SRC_TOP;
    end else if (c == far && r > d) begin
      dir = SRC_RIGHT;
    end else if (r == far && c < far) begin
      dir = SRC_BOTTOM;
    end else begin
      dir = SRC_LEFT;
    end
    return dir;
  endfunction

endpackage

### sv/matrix_ring_rotate_by_one.sv
// A released result goes through the read stage and then the output queue to the output.
// Throughput: one item per cycle while the output queue has room. The first N items of a frame
// give no result, each later one gives one and the last gives N+1, so input stalls there
// for the flush. The single window read port sets the sustained rate: one result per cycle.
// Reset clears the counters and the output queue and sets the size to 4; the window memory
// is left as is, with no clearing pass, since a frame reads only entries it wrote itself.
`timescale 1ns / 1ps

module matrix_ring_rotate_by_one
  import mrr_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items, row-major.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [ELEMENT_WIDTH-1:0] element_i,
  // Result items, row-major rotated matrix.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [ELEMENT_WIDTH-1:0] rotated_element_o,
  output logic                            run_last_o,
  output logic                            frame_last_o,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_AW-1:0]               paddr,
  input  logic [APB_DW-1:0]               pwdata,
  output logic [APB_DW-1:0]               prdata,
  output logic                            pready
);

  // ---------------------------------------------------------------------------
  // Configuration register. Writing the size also starts a new frame.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_size_q;
  logic             cfg_sel;
  logic             cfg_we;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[APB_AW-1:2] == REG_MATRIX_SIZE);
  assign cfg_we  = psel && penable && pwrite && cfg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= RESET_SIZE;
    end else if (cfg_we) begin
      cfg_size_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata[CFG_W-1:0] = cfg_size_q;
    end
  end

  // The effective size: zero acts as one, anything above MAX_N as MAX_N.
  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W-1:0] n_m1;
  logic [SLOT_W:0]   two_n;
  logic [SLOT_W:0]   n_ext;
  logic [SLOT_W-1:0] slot_max;

  always_comb begin
    if (cfg_size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (cfg_size_q > CFG_W'(MAX_N)) begin
      n_eff = SIZE_W'(MAX_N);
    end else begin
      n_eff = SIZE_W'(cfg_size_q);
    end
  end

  assign n_m1     = n_eff - SIZE_W'(1);
  assign n_ext    = (SLOT_W + 1)'(n_eff);
  assign two_n    = n_ext + n_ext;
  assign slot_max = SLOT_W'(two_n - (SLOT_W + 1)'(1));

  // ---------------------------------------------------------------------------
  // Input side: position of the next element and its slot in the window.
  // Element p of a frame lives in slot p mod 2N.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] in_row_q, in_row_d;
  logic [SIZE_W-1:0] in_col_q, in_col_d;
  logic [SLOT_W-1:0] wp_q, wp_d;
  logic              in_last;
  logic              in_emits;
  logic              in_acc;

  assign in_last  = (in_row_q == n_m1) && (in_col_q == n_m1);
  // From the second row on, every element releases the result one row above it.
  assign in_emits = in_last || (in_row_q != '0);

  // ---------------------------------------------------------------------------
  // Result side: position and slot of the next result, and the flush of the
  // last row after the final element of a frame.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] o_row_q, o_row_d;
  logic [SIZE_W-1:0] o_col_q, o_col_d;
  logic [SLOT_W-1:0] op_q, op_d;
  logic              flush_q, flush_d;

  // Output queue bookkeeping, needed here to decide whether a read may start.
  logic [1:0] fifo_cnt_q;
  logic       s1_valid_q;
  logic       pop;
  logic [2:0] occ_after;
  logic       can_issue;
  logic       issue;

  assign pop       = out_valid_o && out_ready_i;
  assign occ_after = 3'(fifo_cnt_q) + 3'(s1_valid_q) - 3'(pop);
  // The queue holds two items; a new read may start if at most one stays behind.
  assign can_issue = (occ_after <= 3'd1);

  assign in_ready_o = !flush_q && can_issue;
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (in_acc && in_emits) || (flush_q && can_issue);

  // Source of the next result: direction, matrix position and window slot.
  src_dir_e          dir;
  logic [SIZE_W-1:0] src_row;
  logic [SIZE_W-1:0] src_col;
  logic [SLOT_W-1:0] src_slot;
  logic [SLOT_W-1:0] op_inc;
  logic [SLOT_W-1:0] op_dec;
  logic [SLOT_W-1:0] op_half;
  logic [SLOT_W:0]   op_ext;
  logic [SIZE_W-1:0] cur_row;
  logic [SIZE_W-1:0] cur_col;
  job_t              job;

  assign dir     = src_dir(o_row_q, o_col_q, n_eff);
  assign op_ext  = (SLOT_W + 1)'(op_q);
  assign op_inc  = (op_q == slot_max) ? '0 : op_q + SLOT_W'(1);
  assign op_dec  = (op_q == '0) ? slot_max : op_q - SLOT_W'(1);
  // Moving N slots either way is the same step modulo 2N.
  assign op_half = (op_ext >= n_ext) ? SLOT_W'(op_ext - n_ext) : SLOT_W'(op_ext + n_ext);

  always_comb begin
    src_row  = o_row_q;
    src_col  = o_col_q;
    src_slot = op_q;
    unique case (dir)
      SRC_CENTRE: begin
        src_slot = op_q;
      end
      SRC_TOP: begin
        src_col  = o_col_q - SIZE_W'(1);
        src_slot = op_dec;
      end
      SRC_RIGHT: begin
        src_row  = o_row_q - SIZE_W'(1);
        src_slot = op_half;
      end
      SRC_BOTTOM: begin
        src_col  = o_col_q + SIZE_W'(1);
        src_slot = op_inc;
      end
      SRC_LEFT: begin
        src_row  = o_row_q + SIZE_W'(1);
        src_slot = op_half;
      end
      default: begin
        src_slot = op_q;
      end
    endcase
  end

  // The element being accepted (or, during the flush, the final element of the
  // frame) is not in the window yet; a result taking it bypasses the memory.
  assign cur_row = flush_q ? n_m1 : in_row_q;
  assign cur_col = flush_q ? n_m1 : in_col_q;

  always_comb begin
    job.use_cur    = (src_row == cur_row) && (src_col == cur_col);
    job.frame_last = (o_row_q == n_m1) && (o_col_q == n_m1);
    // The final element of a frame releases several results; only the final one closes its run.
    job.run_last   = !(flush_q || in_last) || job.frame_last;
  end

  // Next-state logic for both position trackers and the flush flag.
  always_comb begin
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    wp_d     = wp_q;
    o_row_d  = o_row_q;
    o_col_d  = o_col_q;
    op_d     = op_q;
    flush_d  = flush_q;

    if (in_acc) begin
      if (in_last) begin
        in_row_d = '0;
        in_col_d = '0;
        wp_d     = '0;
        flush_d  = 1'b1;
      end else begin
        wp_d = (wp_q == slot_max) ? '0 : wp_q + SLOT_W'(1);
        if (in_col_q == n_m1) begin
          in_col_d = '0;
          in_row_d = in_row_q + SIZE_W'(1);
        end else begin
          in_col_d = in_col_q + SIZE_W'(1);
        end
      end
    end

    if (issue) begin
      if (job.frame_last) begin
        o_row_d = '0;
        o_col_d = '0;
        op_d    = '0;
        flush_d = 1'b0;
      end else begin
        op_d = op_inc;
        if (o_col_q == n_m1) begin
          o_col_d = '0;
          o_row_d = o_row_q + SIZE_W'(1);
        end else begin
          o_col_d = o_col_q + SIZE_W'(1);
        end
      end
    end

    // Size writes restart the frame; the user must issue them only while idle (not enforced).
    if (cfg_we) begin
      in_row_d = '0;
      in_col_d = '0;
      wp_d     = '0;
      o_row_d  = '0;
      o_col_d  = '0;
      op_d     = '0;
      flush_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
      wp_q     <= '0;
      o_row_q  <= '0;
      o_col_q  <= '0;
      op_q     <= '0;
      flush_q  <= 1'b0;
    end else begin
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      wp_q     <= wp_d;
      o_row_q  <= o_row_d;
      o_col_q  <= o_col_d;
      op_q     <= op_d;
      flush_q  <= flush_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Window memory. The final element of a frame is never written: its slot may
  // still hold an older element that the flush has to read, so it is kept in
  // the hold register instead. A read of the slot being written returns the
  // old element, which is the one wanted.
  // ---------------------------------------------------------------------------
  logic [ELEMENT_WIDTH-1:0]        rd_data;
  logic signed [ELEMENT_WIDTH-1:0] hold_q;

  mrr_ram #(
    .DEPTH (WIN_DEPTH),
    .WIDTH (ELEMENT_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (in_acc && !in_last),
    .waddr_i (wp_q),
    .wdata_i (element_i),
    .re_i    (issue),
    .raddr_i (src_slot),
    .rdata_o (rd_data)
  );

  // Holds the element of the item accepted last; during the flush that is the
  // final element of the frame.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q <= element_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage and two-entry output queue.
  // ---------------------------------------------------------------------------
  job_t      s1_job_q;
  out_item_t push_item;
  out_item_t fifo_q [2];
  logic      wr_ptr_q;
  logic      rd_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_job_q <= job;
    end
  end

  always_comb begin
    push_item.element    = s1_job_q.use_cur ? hold_q : $signed(rd_data);
    push_item.run_last   = s1_job_q.run_last;
    push_item.frame_last = s1_job_q.frame_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      fifo_cnt_q <= fifo_cnt_q + 2'(s1_valid_q) - 2'(pop);
      if (s1_valid_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= push_item;
    end
  end

  assign out_valid_o       = (fifo_cnt_q != '0);
  assign rotated_element_o = fifo_q[rd_ptr_q].element;
  assign run_last_o        = fifo_q[rd_ptr_q].run_last;
  assign frame_last_o      = fifo_q[rd_ptr_q].frame_last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !pop |-> fifo_cnt_q < 2'd2)
    else $error("output queue written while full");

  a_frame_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> run_last_o)
    else $error("frame end not marked as end of run");

  a_last_starts_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last && !cfg_we |=> flush_q || (s1_valid_q && s1_job_q.frame_last))
    else $error("final element did not start the row flush");

  a_slots_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SLOT_W + 1)'(wp_q) < two_n && (SLOT_W + 1)'(op_q) < two_n)
    else $error("window slot outside the 2N window");

endmodule

### sv/mrr_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// Read and write of the same entry in one cycle return the old data.
`timescale 1ns / 1ps

module mrr_ram #(
  parameter  int unsigned DEPTH = 64,
  parameter  int unsigned WIDTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/mrr_rotation_check.sv
// Watches both item channels and the register port of the ring rotator, and
// predicts and compares every result. Depends on mrr_pkg for widths and types.
`timescale 1ns / 1ps

module mrr_rotation_check
  import mrr_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic signed [ELEMENT_WIDTH-1:0] element_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [ELEMENT_WIDTH-1:0] rotated_element_i,
  input  logic                            run_last_i,
  input  logic                            frame_last_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [APB_AW-1:0]               paddr_i,
  input  logic [APB_DW-1:0]               pwdata_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);

  logic [ELEMENT_WIDTH-1:0] ring_mem [WIN_DEPTH];
  logic [CFG_W-1:0]         size_reg;
  int unsigned              row_pos;
  int unsigned              col_pos;
  int unsigned              next_out;
  out_item_t                rotated_q [$];

  initial begin
    pending_o = 0;
    errors_o  = 0;
  end

  // Every mismatch prints one line and is counted.
  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors_o++;
  endtask

  // Input index whose element lands at output position j of an n x n matrix.
  function automatic int unsigned origin_index(input int unsigned j, input int unsigned n);
    int unsigned r;
    int unsigned c;
    int unsigned layer;
    int unsigned far_edge;
    r     = j / n;
    c     = j % n;
    layer = r;
    if (c < layer) layer = c;
    if (n - 1 - r < layer) layer = n - 1 - r;
    if (n - 1 - c < layer) layer = n - 1 - c;
    far_edge = n - 1 - layer;
    if (r == layer && c == layer && far_edge == layer) return j;
    if (r == layer && c > layer) return j - 1;
    if (c == far_edge && r > layer) return j - n;
    if (r == far_edge && c < far_edge) return j + 1;
    return j + n;
  endfunction

  // Queue every rotated element that one accepted input releases.
  task automatic rotate_accept(input logic [ELEMENT_WIDTH-1:0] value);
    int unsigned n;
    int unsigned total;
    int unsigned r;
    int unsigned c;
    int unsigned p;
    int unsigned stop;
    int unsigned j;
    int unsigned src;
    out_item_t   item;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > MAX_N) n = MAX_N;
    total = n * n;
    r = (row_pos < n) ? row_pos : n - 1;
    c = (col_pos < n) ? col_pos : n - 1;
    p = r * n + c;
    if (p == total - 1) stop = total;
    else if (p >= n) stop = p - n + 1;
    else stop = 0;
    while (next_out < stop) begin
      j   = next_out;
      src = origin_index(j, n);
      item.element    = (src == p) ? value : ring_mem[src % (2 * n)];
      item.run_last   = (j + 1 == stop);
      item.frame_last = (j == total - 1);
      rotated_q.insert(rotated_q.size(), item);
      next_out++;
    end
    ring_mem[p % (2 * n)] = value;
    if (p == total - 1) begin
      row_pos  = 0;
      col_pos  = 0;
      next_out = 0;
    end else if (c + 1 >= n) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      size_reg = RESET_SIZE;
      row_pos  = 0;
      col_pos  = 0;
      next_out = 0;
      rotated_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", rotated_element_i));
        end else begin
          want = rotated_q.pop_front();
          if (rotated_element_i !== want.element) begin
            note_mismatch($sformatf("rotated_element got %h want %h",
                                    rotated_element_i, want.element));
          end
          if (run_last_i !== want.run_last) begin
            note_mismatch($sformatf("run_last got %b want %b", run_last_i, want.run_last));
          end
          if (frame_last_i !== want.frame_last) begin
            note_mismatch($sformatf("frame_last got %b want %b",
                                    frame_last_i, want.frame_last));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] == REG_MATRIX_SIZE) begin
        size_reg = pwdata_i[CFG_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
        next_out = 0;
      end
      if (in_valid_i && in_ready_i) begin
        rotate_accept(element_i);
      end
    end
    pending_o = rotated_q.size();
  end

endmodule

### dv/matrix_ring_rotate_by_one_tb.sv
// Top of the ring rotator testbench: clock, reset, item and register stimulus, and verdict.
// Depends on mrr_pkg, the block itself and mrr_rotation_check, which predicts and compares.
`timescale 1ns / 1ps

module matrix_ring_rotate_by_one_tb
  import mrr_pkg::*;
();

  // Cycles allowed after the last expected result for work still in flight.
  // The block registers a result in its read stage and output queue; this leaves margin.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Hard stop, several times the length of a run in which every item releases
  // the most results and both sides idle as long as they ever do.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // Length of the one long back-pressure stretch on the result side.
  localparam int unsigned LONG_STALL    = 400;
  // Size of the random part, in items, and where the idle-free tail begins.
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned QUIET_FROM    = 150;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [ELEMENT_WIDTH-1:0] element;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [ELEMENT_WIDTH-1:0] rotated_element;
  logic                            run_last;
  logic                            frame_last;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [APB_AW-1:0]               paddr;
  logic [APB_DW-1:0]               pwdata;
  logic [APB_DW-1:0]               prdata;
  logic                            pready;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycle_count;

  // Shared between the sender and the receiver: the chance (in percent) that
  // either side starts an idle burst, and a flag that turns idling off for
  // the final stretch of the run.
  int unsigned idle_pct;
  bit          quiet;
  // Raised once by the sender; the receiver then holds off by itself.
  bit          long_stall_go;

  matrix_ring_rotate_by_one dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .element_i         (element),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .rotated_element_o (rotated_element),
    .run_last_o        (run_last),
    .frame_last_o      (frame_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  mrr_rotation_check u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .element_i         (element),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .rotated_element_i (rotated_element),
    .run_last_i        (run_last),
    .frame_last_i      (frame_last),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .pending_o         (pending),
    .errors_o          (errors)
  );

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side. Ready changes only at falling edges. Idle bursts start at random;
  // the single long hold-off is counted here so that the sender keeps offering
  // items meanwhile and the block has to fill up and push back on its input.
  initial begin
    int unsigned hold;
    int unsigned long_left;
    bit          long_done;
    hold      = 0;
    long_left = 0;
    long_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_go && !long_done) begin
        long_done = 1'b1;
        long_left = LONG_STALL;
      end
      if (long_left > 0) begin
        long_left--;
        out_ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < idle_pct) begin
        hold = $urandom_range(15, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Corner values for the directed frames: both signed extremes, zero, minus one,
  // alternating bits, a one at bit 0 or 62, half-word masks, near-extremes and random.
  function automatic logic [ELEMENT_WIDTH-1:0] corner_value(input int unsigned i);
    case (i % 16)
      0:       return {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4:       return 64'h5555_5555_5555_5555;
      5:       return 64'hAAAA_AAAA_AAAA_AAAA;
      6:       return 64'h1;
      7:       return 64'h4000_0000_0000_0000;
      8:       return 64'hFFFF_FFFF_0000_0000;
      9:       return 64'h0000_0000_FFFF_FFFF;
      10:      return 64'h8000_0000_0000_0001;
      11:      return 64'h7FFF_FFFF_FFFF_FFFE;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly full-width random values, with the extremes mixed in now and then.
  function automatic logic [ELEMENT_WIDTH-1:0] pick_element();
    case ($urandom_range(15))
      0:       return {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item and wait until it is taken. Valid stays high from one item
  // to the next unless an idle burst lowers it, and it is only ever touched
  // once per falling edge.
  task automatic push_element(input logic [ELEMENT_WIDTH-1:0] value);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(15, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    element  <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Full idle: drained, plus the pipeline's latency for items that release
  // no result, so that a register write cannot overtake work in flight.
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_size(input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_MATRIX_SIZE, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned      random_items;
    int unsigned      n_eff;
    int unsigned      count;
    logic [CFG_W-1:0] size_field;
    logic [APB_DW-1:0] word;
    bit               need_write;

    in_valid      = 1'b0;
    element       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_n         = 1'b0;
    idle_pct      = 0;
    quiet         = 1'b0;
    long_stall_go = 1'b0;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. First a whole 4 x 4 frame at the reset size: twelve corner values,
    // then four random values in the bottom row.
    idle_pct = 20;
    for (int i = 0; i < 16; i++) push_element(corner_value(i));

    // Size one passes each item straight through as a frame of its own.
    quiesce();
    write_size(32'd1);
    push_element(corner_value(0));
    push_element(corner_value(1));

    // Size zero is treated as size one.
    quiesce();
    write_size(32'd0);
    push_element(corner_value(3));

    // Smallest real ring: 2 x 2, where every element sits on a corner.
    quiesce();
    write_size(32'd2);
    for (int i = 4; i < 8; i++) push_element(corner_value(i));

    // Largest size, the first rows of a frame. Early on the receiver holds off
    // for a long stretch while items keep coming; later the sender pauses until
    // every result so far has come out, then resumes mid-frame. The register
    // write that follows starts a fresh frame.
    quiesce();
    write_size(32'd32);
    idle_pct = 10;
    for (int i = 0; i < 200; i++) begin
      if (i == 100) long_stall_go = 1'b1;
      if (i == 160) drain_results();
      push_element(pick_element());
    end

    // A size above the maximum is clamped to it. This frame is left unfinished
    // on purpose; the register write that follows starts a fresh frame.
    quiesce();
    write_size(32'd63);
    repeat (60) push_element(pick_element());
    quiesce();

    // Random part: mostly complete frames of small size, some back to back at
    // the same size, some cut short and followed by a new size. Upper bits of
    // the written word are sometimes random and must be ignored.
    random_items = 0;
    need_write   = 1'b1;
    n_eff        = 1;
    while (random_items < RANDOM_ITEMS) begin
      // The tail of the run has no idling on either side.
      if (random_items >= QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (need_write || $urandom_range(2) == 0) begin
        quiesce();
        if ($urandom_range(19) < 16) size_field = CFG_W'($urandom_range(8, 1));
        else size_field = CFG_W'($urandom_range(16, 9));
        word = $urandom_range(1) ? $urandom : '0;
        word[CFG_W-1:0] = size_field;
        write_size(word);
        n_eff = size_field;
      end
      count      = n_eff * n_eff;
      need_write = 1'b0;
      if (count > 1 && $urandom_range(7) == 0) begin
        count      = $urandom_range(count - 1, 1);
        need_write = 1'b1;
      end
      // The last frame is cut at the item budget.
      if (count > RANDOM_ITEMS - random_items) begin
        count      = RANDOM_ITEMS - random_items;
        need_write = 1'b1;
      end
      repeat (count) push_element(pick_element());
      random_items += count;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
